FILE: hw/rtl/gfl_pkg.sv
// Shared types and constants for the growing free-list node pool.
package gfl_pkg;

   localparam int unsigned IDX_BITS = 10;
   localparam int unsigned CAP_BITS = 11;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 11'd4;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef struct packed {
      logic                action;
      logic [IDX_BITS-1:0] free_index;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] granted_index;
      logic                ok;
   } rsp_type;

endpackage

FILE: hw/rtl/gfl_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module gfl_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/growing_free_list_node_pool_core.sv
// Top level of the growing free-list node pool: allocate and free node indices.
// Timing: a free or a fresh-region allocate shows its beat on rsp in the cycle after
//   acceptance; an allocate that pops the free list passes through ST_POP first.
// Throughput: one beat per cycle for frees and fresh allocates while rsp does not stall;
//   a pop holds off new requests in ST_POP while the next-link memory is read.
// Reset (synchronous, active high): free list empty, no region open, capacity 4.
//   The next-link memory is not cleared; entries are read only after a free writes them.
module growing_free_list_node_pool_core
   import gfl_pkg::*;
#(
   parameter int unsigned STORE_NODES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   // configuration: initial_capacity
   input  logic                csr_we,
   input  logic [CAP_BITS-1:0] csr_wdata
);

   // store index width, pointer width (holds STORE_NODES itself), and
   // a wide working width for region arithmetic (2x region, capacity, free index)
   localparam int unsigned AW  = (STORE_NODES > 1) ? $clog2(STORE_NODES) : 1;
   localparam int unsigned PW  = $clog2(STORE_NODES + 1);
   localparam int unsigned WW  = (PW + 1 > CAP_BITS + 1) ? PW + 1 : CAP_BITS + 1;
   localparam logic [WW-1:0] STORE_W = WW'(STORE_NODES);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_POP  = 1'b1;

   // control state
   logic                state_ff, state_in;
   logic [CAP_BITS-1:0] init_cap_ff, init_cap_in;
   logic [AW-1:0]       list_head_ff, list_head_in;
   logic                list_nonempty_ff, list_nonempty_in;
   logic [PW-1:0]       fresh_next_ff, fresh_next_in;
   logic [PW-1:0]       fresh_end_ff, fresh_end_in;
   logic [PW-1:0]       region_size_ff, region_size_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // link memory: {link valid, next index}
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [AW:0]   ram_wdata;
   logic [AW:0]   ram_rdata;

   logic          accept;
   logic          slot_free;
   logic [WW-1:0] fidx_w;
   logic          free_in_store;
   logic          need_region;
   logic [WW-1:0] want;
   logic [WW-1:0] room;
   logic          alloc_fail;
   logic [PW-1:0] grant_ptr;
   logic [WW-1:0] grant_w;
   logic [WW-1:0] head_w;

   // output slot is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !slot_free;
   assign accept    = req_valid && !req_stall;

   assign fidx_w        = {{(WW-IDX_BITS){1'b0}}, req_data.free_index};
   assign free_in_store = fidx_w < STORE_W;

   // fresh region bookkeeping
   assign need_region = fresh_next_ff >= fresh_end_ff;
   assign want        = (region_size_ff == '0) ? {{(WW-CAP_BITS){1'b0}}, init_cap_ff}
                                               : {{(WW-PW){1'b0}}, region_size_ff} << 1;
   assign room        = STORE_W - {{(WW-PW){1'b0}}, fresh_end_ff};
   assign alloc_fail  = need_region && ((want == '0) || (want > room));
   assign grant_ptr   = need_region ? fresh_end_ff : fresh_next_ff;
   assign grant_w     = {{(WW-PW){1'b0}}, grant_ptr};
   assign head_w      = {{(WW-AW){1'b0}}, list_head_ff};

   // pushes write the entry; pops read it later, never in the same cycle as the write
   assign ram_we    = accept && (req_data.action == ACT_FREE) && free_in_store;
   assign ram_waddr = fidx_w[AW-1:0];
   assign ram_wdata = {list_nonempty_ff, list_head_ff};

   gfl_ram #(
      .WIDTH (AW + 1),
      .DEPTH (STORE_NODES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (list_head_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in         = state_ff;
      init_cap_in      = init_cap_ff;
      list_head_in     = list_head_ff;
      list_nonempty_in = list_nonempty_ff;
      fresh_next_in    = fresh_next_ff;
      fresh_end_in     = fresh_end_ff;
      region_size_in   = region_size_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_data_in      = rsp_data_ff;

      if (csr_we) begin
         init_cap_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.action == ACT_FREE) begin
                  // push; out-of-store index is dropped but still answered
                  if (free_in_store) begin
                     list_head_in     = fidx_w[AW-1:0];
                     list_nonempty_in = 1'b1;
                  end
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.granted_index = '0;
                  rsp_data_in.ok            = 1'b1;
               end else if (list_nonempty_ff) begin
                  // pop: wait for link read of current head
                  state_in = ST_POP;
               end else begin
                  rsp_valid_in = 1'b1;
                  if (alloc_fail) begin
                     rsp_data_in.granted_index = '0;
                     rsp_data_in.ok            = 1'b0;
                  end else begin
                     if (need_region) begin
                        fresh_end_in   = PW'({{(WW-PW){1'b0}}, fresh_end_ff} + want);
                        region_size_in = want[PW-1:0];
                     end
                     fresh_next_in             = PW'(grant_w + WW'(1));
                     rsp_data_in.granted_index = grant_w[IDX_BITS-1:0];
                     rsp_data_in.ok            = 1'b1;
                  end
               end
            end
         end
         ST_POP: begin
            // slot was emptied at acceptance, so it is free here
            list_nonempty_in          = ram_rdata[AW];
            list_head_in              = ram_rdata[AW] ? ram_rdata[AW-1:0] : '0;
            rsp_valid_in              = 1'b1;
            rsp_data_in.granted_index = head_w[IDX_BITS-1:0];
            rsp_data_in.ok            = 1'b1;
            state_in                  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         init_cap_ff      <= CAP_RESET;
         list_head_ff     <= '0;
         list_nonempty_ff <= 1'b0;
         fresh_next_ff    <= '0;
         fresh_end_ff     <= '0;
         region_size_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         init_cap_ff      <= init_cap_in;
         list_head_ff     <= list_head_in;
         list_nonempty_ff <= list_nonempty_in;
         fresh_next_ff    <= fresh_next_in;
         fresh_end_ff     <= fresh_end_in;
         region_size_ff   <= region_size_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the pop wait ends in the next cycle, back in idle, and always yields a beat
   a_pop_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |=> state_ff == ST_IDLE && rsp_valid_ff)
      else $error("pop did not complete in one cycle");

   // fresh pointer never passes end of open region
   a_fresh_order: assert property (@(posedge clock) disable iff (reset)
      fresh_next_ff <= fresh_end_ff)
      else $error("fresh_next beyond fresh_end");

   // failed allocate leaves region untouched and reports failure
   a_fail_stable: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.action == ACT_ALLOC && !list_nonempty_ff && alloc_fail
      |=> $stable(fresh_end_ff) && $stable(region_size_ff) && !rsp_data_ff.ok)
      else $error("failed allocate changed region state");

   // an in-store free always leaves a nonempty list headed by that node
   a_push_head: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> list_nonempty_ff && list_head_ff == $past(ram_waddr))
      else $error("push did not update list head");

   // response slot never overwritten while held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !accept && state_ff == ST_IDLE)
      else $error("new work while response stalled");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the growing free-list node pool core.
module tb_top
   import gfl_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned POOL_NODES = 1024;

   // Directed rows: either a capacity write or one request beat, with the
   // response typed in where it is obvious, otherwise taken from the shadow pool.
   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [CAP_BITS-1:0] cap_value;
      req_type             beat;
      logic                typed;
      rsp_type             typed_rsp;
   } step_row_type;

   // DUT ports; every input is known from time zero.
   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_we    = 1'b0;
   logic [CAP_BITS-1:0] csr_wdata = '0;

   // Shadow copy of the pool: capacity register, free-list head and links,
   // and the fresh-region pointers.
   logic [CAP_BITS-1:0] cap_reg;
   logic [IDX_BITS-1:0] head;
   logic                head_valid;
   logic [IDX_BITS-1:0] link_mem  [POOL_NODES];
   bit                  link_live [POOL_NODES];
   int unsigned         fresh_next;
   int unsigned         fresh_end;
   int unsigned         region_len;

   // Responses still owed by the DUT, oldest first.
   rsp_type     pending_grants [$];
   rsp_type     oldest;
   // Nodes the stimulus believes are handed out; frees are drawn from here.
   logic [IDX_BITS-1:0] live_nodes [$];
   int unsigned mismatch_count = 0;
   int unsigned fail_total     = 0;
   // Receiver hold-off request, in cycles; zero means none pending.
   int unsigned hold_cycles    = 0;
   // Set for the last stretch of the run: no idling on either side.
   bit          quiet          = 1'b0;

   growing_free_list_node_pool_core #(
      .STORE_NODES (POOL_NODES)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow pool
   // ------------------------------------------------------------------
   // Applies one accepted request beat to the shadow pool and returns the
   // response the DUT owes for it.
   function automatic rsp_type predict_grant(input req_type r);
      rsp_type             g;
      logic [IDX_BITS-1:0] top;
      int unsigned         want;
      g.granted_index = '0;
      g.ok            = 1'b1;
      if (r.action == ACT_FREE) begin
         // Frees are not checked: a double free or a free of a node never
         // handed out is pushed like any other.
         if (r.free_index < POOL_NODES) begin
            link_mem[r.free_index]  = head;
            link_live[r.free_index] = head_valid;
            head                    = r.free_index;
            head_valid              = 1'b1;
         end
      end else if (head_valid) begin
         // Pop: newest freed node goes out first.
         top             = head;
         g.granted_index = top;
         head_valid      = link_live[top];
         head            = link_live[top] ? link_mem[top] : '0;
      end else begin
         // List empty: carve from the fresh region, opening a new one
         // (first at the register's size, then doubling) when used up.
         if (fresh_next >= fresh_end) begin
            want = (region_len == 0) ? cap_reg : 2 * region_len;
            // zero-length region or no room left in the store: fail, no change
            if (want == 0 || want > POOL_NODES - fresh_end) begin
               g.ok = 1'b0;
            end else begin
               fresh_next = fresh_end;
               fresh_end  = fresh_end + want;
               region_len = want;
            end
         end
         if (g.ok) begin
            g.granted_index = fresh_next[IDX_BITS-1:0];
            fresh_next      = fresh_next + 1;
         end
      end
      return g;
   endfunction

   function automatic step_row_type row_csr(input logic [CAP_BITS-1:0] v);
      step_row_type s;
      s           = '0;
      s.kind      = ROW_CSR;
      s.cap_value = v;
      return s;
   endfunction

   function automatic step_row_type row_beat(input logic act,
                                             input logic [IDX_BITS-1:0] idx);
      step_row_type s;
      s                 = '0;
      s.kind            = ROW_BEAT;
      s.beat.action     = act;
      s.beat.free_index = idx;
      return s;
   endfunction

   function automatic step_row_type row_typed(input logic act,
                                              input logic [IDX_BITS-1:0] idx,
                                              input logic [IDX_BITS-1:0] g,
                                              input logic ok);
      step_row_type s;
      s                         = row_beat(act, idx);
      s.typed                   = 1'b1;
      s.typed_rsp.granted_index = g;
      s.typed_rsp.ok            = ok;
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // Offers one beat and holds it until accepted; called on a rising edge,
   // returns on the edge of acceptance.
   task automatic push_beat(input req_type r, input logic typed, input rsp_type typed_rsp);
      rsp_type p;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      p = predict_grant(r);
      if (r.action == ACT_ALLOC && p.ok) live_nodes.push_back(p.granted_index);
      if (!p.ok) fail_total++;
      pending_grants.push_back(typed ? typed_rsp : p);
   endtask

   // Occasional random sender gap, off in the quiet stretch.
   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   // One random beat: allocate with the given odds, otherwise free a node
   // that is out, with a few stray frees of any index mixed in.
   task automatic random_beat(input int unsigned alloc_pct);
      req_type     r;
      int unsigned pick;
      r.free_index = IDX_BITS'($urandom_range(0, POOL_NODES - 1));
      if ($urandom_range(0, 99) < alloc_pct) begin
         r.action = ACT_ALLOC;
      end else begin
         r.action = ACT_FREE;
         if (live_nodes.size() != 0 && $urandom_range(0, 19) != 0) begin
            pick             = $urandom_range(0, live_nodes.size() - 1);
            r.free_index     = live_nodes[pick];
            live_nodes[pick] = live_nodes[live_nodes.size() - 1];
            void'(live_nodes.pop_back());
         end
      end
      push_beat(r, 1'b0, '0);
      sender_gap();
   endtask

   // Capacity writes happen only with the pool drained: no beat offered,
   // nothing owed, and then a settling wait before the write.
   task automatic write_capacity(input logic [CAP_BITS-1:0] v);
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      cap_reg    = v;
   endtask

   // ------------------------------------------------------------------
   // Response side: stall bursts, free-running stretches, and one long
   // hold-off when the sender asks for it.
   // ------------------------------------------------------------------
   initial begin
      forever begin
         if (hold_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Every accepted response beat is matched against the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            $error("rsp beat with nothing owed: granted_index %0d ok %0b",
                   rsp_data.granted_index, rsp_data.ok);
            mismatch_count++;
         end else begin
            oldest = pending_grants.pop_front();
            if (rsp_data.granted_index !== oldest.granted_index) begin
               $error("granted_index: expected %0d, got %0d",
                      oldest.granted_index, rsp_data.granted_index);
               mismatch_count++;
            end
            if (rsp_data.ok !== oldest.ok) begin
               $error("ok: expected %0b, got %0b", oldest.ok, rsp_data.ok);
               mismatch_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      step_row_type plan [25];
      int unsigned  n;
      int unsigned  fail_mark;

      cap_reg    = CAP_RESET;
      head       = '0;
      head_valid = 1'b0;
      fresh_next = 0;
      fresh_end  = 0;
      region_len = 0;
      foreach (link_live[i]) link_live[i] = 1'b0;

      plan = '{
         // zero capacity: first region would be empty
         row_csr(11'd0),
         row_typed(ACT_ALLOC, 10'd0,    10'd0, 1'b0),
         // largest register value, and one past the store: neither fits
         row_csr(11'd2047),
         row_typed(ACT_ALLOC, 10'h3FF,  10'd0, 1'b0),
         row_csr(11'd1025),
         row_typed(ACT_ALLOC, 10'd0,    10'd0, 1'b0),
         // capacity 1: regions of 1, 2, 4, ... up to exhaustion later on
         row_csr(11'd1),
         row_typed(ACT_ALLOC, 10'd0,    10'd0, 1'b1),
         row_beat (ACT_ALLOC, 10'h155),
         row_beat (ACT_ALLOC, 10'd0),
         row_beat (ACT_ALLOC, 10'h2AA),
         row_typed(ACT_FREE,  10'd1,    10'd0, 1'b1),
         row_typed(ACT_FREE,  10'd3,    10'd0, 1'b1),
         // pops come back newest first
         row_beat (ACT_ALLOC, 10'd0),
         row_beat (ACT_ALLOC, 10'd0),
         row_beat (ACT_ALLOC, 10'd0),
         // top index, never handed out, pushed under a real node
         row_typed(ACT_FREE,  10'h3FF,  10'd0, 1'b1),
         row_typed(ACT_FREE,  10'd2,    10'd0, 1'b1),
         row_beat (ACT_ALLOC, 10'd0),
         row_beat (ACT_ALLOC, 10'd0),
         row_beat (ACT_ALLOC, 10'd0),
         row_typed(ACT_FREE,  10'd0,    10'd0, 1'b1),
         row_typed(ACT_FREE,  10'd512,  10'd0, 1'b1),
         row_beat (ACT_ALLOC, 10'h3FF),
         row_beat (ACT_ALLOC, 10'd0)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed rows in order, with random sender gaps; write rows drain the pool first.
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            write_capacity(plan[i].cap_value);
         end else begin
            push_beat(plan[i].beat, plan[i].typed, plan[i].typed_rsp);
            sender_gap();
         end
      end
      // Directed allocates took nodes out of the store; forget the strays
      // so that random frees start from the real survivors.
      live_nodes.delete();
      live_nodes.push_back(10'd0);
      live_nodes.push_back(10'd1);
      live_nodes.push_back(10'd2);
      live_nodes.push_back(10'd3);
      live_nodes.push_back(10'd4);
      live_nodes.push_back(10'd5);

      // A region is already open, so capacity writes from here on are inert
      // but must still be accepted.
      write_capacity(11'd1024);

      // Mixed traffic; partway in the receiver holds off long enough for the
      // pool to back up and stall the request side.
      for (n = 0; n < 200; n++) begin
         if (n == 60) hold_cycles = 300;
         random_beat(60);
      end

      write_capacity(11'($urandom_range(1, 1024)));

      // Mostly allocates: walk every region up to the end of the store, then
      // keep asking so the exhausted case shows up repeatedly.
      fail_mark = fail_total + 30;
      for (n = 0; n < 1400 && fail_total < fail_mark; n++) random_beat(97);

      write_capacity(11'd2047);

      // Mostly frees: long free-list chains, then pops through them.
      for (n = 0; n < 200; n++) random_beat(25);

      write_capacity(11'd1);

      // Final stretch at full rate on both sides.
      quiet = 1'b1;
      for (n = 0; n < 200; n++) random_beat(55);
      req_valid <= 1'b0;

      while (pending_grants.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Run limit: several times the slowest legal run.
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
